@@ design/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register map, configuration struct and controller commands
// for the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int DATA_W  = 32;
   localparam int STEP_W  = 16;
   localparam int INTEG_W = 48;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 80;
   localparam int SUM_W   = 63;
   localparam int ADDR_W  = 5;
   localparam int IDX_W   = 3;
   localparam int DT_FRAC = 16;

   typedef logic signed [DATA_W-1:0]  data_type;
   typedef logic        [STEP_W-1:0]  step_type;
   typedef logic signed [INTEG_W-1:0] integ_type;

   localparam data_type  DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type  DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
   localparam integ_type INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam integ_type INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] TERM_HI = ACC_W'(64'sh1000_0000_0000_0000);
   localparam logic signed [ACC_W-1:0] TERM_LO = -TERM_HI;

   typedef enum logic [IDX_W-1:0] {
      REG_SETPOINT   = 3'd0,
      REG_GAIN_PROP  = 3'd1,
      REG_GAIN_INTEG = 3'd2,
      REG_GAIN_DERIV = 3'd3,
      REG_DRV_UPPER  = 3'd4,
      REG_DRV_LOWER  = 3'd5,
      REG_TIME_STEP  = 3'd6,
      REG_INV_STEP   = 3'd7
   } reg_idx_type;

   typedef struct packed {
      data_type setpoint;
      data_type gain_prop;
      data_type gain_integ;
      data_type gain_deriv;
      data_type drive_upper;
      data_type drive_lower;
      step_type time_step;
      step_type inv_time_step;
   } cfg_type;

   localparam step_type TIME_STEP_RST = 16'd655;
   localparam step_type INV_STEP_RST  = 16'd100;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_INC,
      MUL_DER,
      MUL_PRP,
      MUL_ILO,
      MUL_IHI,
      MUL_DLO,
      MUL_DHI
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_HIGH
   } acc_op_type;

   typedef enum logic [1:0] {
      TERM_NONE,
      TERM_FIRST,
      TERM_ADD
   } term_op_type;

   typedef struct packed {
      logic        load_err;
      mul_sel_type mul_sel;
      logic        integ;
      logic        deriv_st;
      acc_op_type  acc_op;
      term_op_type term_op;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage

@@ design/pidc_req_if.sv @@
// ----------------------------------------------------------------------------
// pidc_req_if
// Input channel: one measured sample per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pidc_req_if;

   logic               valid;
   logic               ready;
   logic signed [31:0] measured;

   modport source (output valid, output measured, input ready);
   modport sink (input valid, input measured, output ready);

endinterface

@@ design/pidc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pidc_rsp_if
// Result channel: clamped drive and clamp flag per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pidc_rsp_if;

   logic               valid;
   logic               ready;
   logic signed [31:0] drive;
   logic               was_clamped;

   modport source (output valid, output drive, output was_clamped, input ready);
   modport sink (input valid, input drive, input was_clamped, output ready);

endinterface

@@ design/pidc_csr.sv @@
// ----------------------------------------------------------------------------
// pidc_csr
// APB register bank holding setpoint, gains, drive limits and time step.
// ----------------------------------------------------------------------------
module pidc_csr import pidc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_SETPOINT:   cfg_in.setpoint      = pwdata;
            REG_GAIN_PROP:  cfg_in.gain_prop     = pwdata;
            REG_GAIN_INTEG: cfg_in.gain_integ    = pwdata;
            REG_GAIN_DERIV: cfg_in.gain_deriv    = pwdata;
            REG_DRV_UPPER:  cfg_in.drive_upper   = pwdata;
            REG_DRV_LOWER:  cfg_in.drive_lower   = pwdata;
            REG_TIME_STEP:  cfg_in.time_step     = pwdata[STEP_W-1:0];
            REG_INV_STEP:   cfg_in.inv_time_step = pwdata[STEP_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SETPOINT:   prdata = cfg_ff.setpoint;
         REG_GAIN_PROP:  prdata = cfg_ff.gain_prop;
         REG_GAIN_INTEG: prdata = cfg_ff.gain_integ;
         REG_GAIN_DERIV: prdata = cfg_ff.gain_deriv;
         REG_DRV_UPPER:  prdata = cfg_ff.drive_upper;
         REG_DRV_LOWER:  prdata = cfg_ff.drive_lower;
         REG_TIME_STEP:  prdata = {{(32-STEP_W){1'b0}}, cfg_ff.time_step};
         REG_INV_STEP:   prdata = {{(32-STEP_W){1'b0}}, cfg_ff.inv_time_step};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint      <= '0;
         cfg_ff.gain_prop     <= '0;
         cfg_ff.gain_integ    <= '0;
         cfg_ff.gain_deriv    <= '0;
         cfg_ff.drive_upper   <= DATA_MAX;
         cfg_ff.drive_lower   <= DATA_MIN;
         cfg_ff.time_step     <= TIME_STEP_RST;
         cfg_ff.inv_time_step <= INV_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/pidc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pidc_ctrl
// Sequencer issuing one multiplier operation per cycle in its multiply steps to the datapath.
// ----------------------------------------------------------------------------
module pidc_ctrl import pidc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_MINC = 11'b000_0000_0010,
      ST_MDER = 11'b000_0000_0100,
      ST_MPRP = 11'b000_0000_1000,
      ST_MILO = 11'b000_0001_0000,
      ST_MIHI = 11'b000_0010_0000,
      ST_MDLO = 11'b000_0100_0000,
      ST_MDHI = 11'b000_1000_0000,
      ST_ACCD = 11'b001_0000_0000,
      ST_TRMD = 11'b010_0000_0000,
      ST_CLMP = 11'b100_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_err = req_valid;
            if (req_valid) begin
               state_in = ST_MINC;
            end
         end
         ST_MINC: begin
            cmd.mul_sel = MUL_INC;
            state_in    = ST_MDER;
         end
         ST_MDER: begin
            cmd.mul_sel = MUL_DER;
            cmd.integ   = 1'b1;
            state_in    = ST_MPRP;
         end
         ST_MPRP: begin
            cmd.mul_sel  = MUL_PRP;
            cmd.deriv_st = 1'b1;
            state_in     = ST_MILO;
         end
         ST_MILO: begin
            cmd.mul_sel = MUL_ILO;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_MIHI;
         end
         ST_MIHI: begin
            cmd.mul_sel = MUL_IHI;
            cmd.term_op = TERM_FIRST;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_MDLO;
         end
         ST_MDLO: begin
            cmd.mul_sel = MUL_DLO;
            cmd.acc_op  = ACC_HIGH;
            state_in    = ST_MDHI;
         end
         ST_MDHI: begin
            cmd.mul_sel = MUL_DHI;
            cmd.term_op = TERM_ADD;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_ACCD;
         end
         ST_ACCD: begin
            cmd.acc_op = ACC_HIGH;
            state_in   = ST_TRMD;
         end
         ST_TRMD: begin
            cmd.term_op = TERM_ADD;
            state_in    = ST_CLMP;
         end
         ST_CLMP: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/pidc_dp.sv @@
// ----------------------------------------------------------------------------
// pidc_dp
// Datapath: error, shared 33x33 multiplier, integral and derivative state,
// term accumulation, clamp and output register.
// ----------------------------------------------------------------------------
module pidc_dp import pidc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   output status_type status,
   input  data_type   req_measured,
   output data_type   rsp_drive,
   output logic       rsp_was_clamped,
   output logic       rsp_valid,
   input  logic       rsp_ready
);

   data_type                  err_ff, err_in;
   data_type                  last_ff, last_in;
   integ_type                 esum_ff, esum_in;
   integ_type                 deriv_ff, deriv_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   data_type                  drive_ff, drive_in;
   logic                      clamped_ff, clamped_in;
   logic                      valid_ff, valid_in;

   logic signed [DATA_W:0]    err_diff;
   data_type                  err_sat;
   logic signed [MUL_W-1:0]   err_x, delta, mul_a, mul_b;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [ACC_W-1:0]   quot, term;
   logic signed [SUM_W-1:0]   upper_x, lower_x, clamp_v;
   logic                      clamp_hit;

   // error, saturated to 32 bits
   assign err_diff = (DATA_W+1)'(cfg.setpoint) - (DATA_W+1)'(req_measured);
   assign err_sat  = (err_diff[DATA_W] != err_diff[DATA_W-1])
                   ? (err_diff[DATA_W] ? DATA_MIN : DATA_MAX)
                   : err_diff[DATA_W-1:0];
   assign err_in   = cmd.load_err ? err_sat : err_ff;

   // shared multiplier operands
   assign err_x = MUL_W'(err_ff);
   assign delta = err_x - MUL_W'(last_ff);

   always_comb begin
      case (cmd.mul_sel)
         MUL_INC: begin
            mul_a = err_x;
            mul_b = {{(MUL_W-STEP_W){1'b0}}, cfg.time_step};
         end
         MUL_DER: begin
            mul_a = delta;
            mul_b = {{(MUL_W-STEP_W){1'b0}}, cfg.inv_time_step};
         end
         MUL_PRP: begin
            mul_a = MUL_W'(cfg.gain_prop);
            mul_b = err_x;
         end
         MUL_ILO: begin
            mul_a = MUL_W'(cfg.gain_integ);
            mul_b = {1'b0, esum_ff[DATA_W-1:0]};
         end
         MUL_IHI: begin
            mul_a = MUL_W'(cfg.gain_integ);
            mul_b = MUL_W'($signed(esum_ff[INTEG_W-1:DATA_W]));
         end
         MUL_DLO: begin
            mul_a = MUL_W'(cfg.gain_deriv);
            mul_b = {1'b0, deriv_ff[DATA_W-1:0]};
         end
         MUL_DHI: begin
            mul_a = MUL_W'(cfg.gain_deriv);
            mul_b = MUL_W'($signed(deriv_ff[INTEG_W-1:DATA_W]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // integral with floor of the dt product
   assign integ_sum = (INTEG_W+1)'(esum_ff) + (INTEG_W+1)'(prod_ff >>> DT_FRAC);

   always_comb begin
      esum_in = esum_ff;
      if (cmd.integ) begin
         if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            esum_in = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
         end else begin
            esum_in = integ_sum[INTEG_W-1:0];
         end
      end
   end

   // derivative, saturated to 48 bits
   always_comb begin
      deriv_in = deriv_ff;
      last_in  = last_ff;
      if (cmd.deriv_st) begin
         last_in = err_ff;
         if (prod_ff > PROD_W'(INTEG_MAX)) begin
            deriv_in = INTEG_MAX;
         end else if (prod_ff < PROD_W'(INTEG_MIN)) begin
            deriv_in = INTEG_MIN;
         end else begin
            deriv_in = prod_ff[INTEG_W-1:0];
         end
      end
   end

   // product accumulation over low and high halves
   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = ACC_W'(prod_ff);
         ACC_HIGH: acc_in = acc_ff + (ACC_W'(prod_ff) <<< DATA_W);
         default:  acc_in = acc_ff;
      endcase
   end

   // term: floor shift then saturate
   assign quot = acc_ff >>> FRAC_BITS;
   assign term = (quot > TERM_HI) ? TERM_HI : ((quot < TERM_LO) ? TERM_LO : quot);

   always_comb begin
      case (cmd.term_op)
         TERM_FIRST: sum_in = SUM_W'(term);
         TERM_ADD:   sum_in = sum_ff + SUM_W'(term);
         default:    sum_in = sum_ff;
      endcase
   end

   // clamp, lower limit wins
   assign upper_x = SUM_W'(cfg.drive_upper);
   assign lower_x = SUM_W'(cfg.drive_lower);

   always_comb begin
      clamp_v   = sum_ff;
      clamp_hit = 1'b0;
      if (clamp_v > upper_x) begin
         clamp_v   = upper_x;
         clamp_hit = 1'b1;
      end
      if (clamp_v < lower_x) begin
         clamp_v   = lower_x;
         clamp_hit = 1'b1;
      end
   end

   assign drive_in   = cmd.out_load ? clamp_v[DATA_W-1:0] : drive_ff;
   assign clamped_in = cmd.out_load ? clamp_hit : clamped_ff;
   assign valid_in   = cmd.out_load | (valid_ff & ~rsp_ready);

   assign status.out_busy = valid_ff & ~rsp_ready;
   assign rsp_drive       = drive_ff;
   assign rsp_was_clamped = clamped_ff;
   assign rsp_valid       = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= '0;
         esum_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         last_ff  <= last_in;
         esum_ff  <= esum_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      deriv_ff   <= deriv_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      sum_ff     <= sum_in;
      drive_ff   <= drive_in;
      clamped_ff <= clamped_in;
   end

endmodule

@@ design/pid_controller_clamped.sv @@
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Positional PID controller in signed fixed point with a clamped drive output.
//
// Write setpoint, gains, drive limits, dt and 1/dt over the APB port while no
// sample is in flight. Each word on req_if carries one measured sample; each
// word on rsp_if returns the clamped drive and a flag telling whether a limit
// was applied. One result per sample, in order.
// A sample is accepted only while the sequencer is idle, so a new sample is
// taken only after the last one's result has been loaded. The single shared
// 33x33 multiplier sets this pace; it forms seven products per sample, one a
// cycle. The result waits in an output register, so a new sample is accepted
// while it is still pending; if the receiver holds rsp_if.ready low until the
// next result is ready, the sequencer stops in its last step until the
// register frees.
// Reset is synchronous: registers take their documented values, the integral
// and previous error clear, and no result is pending.
// ----------------------------------------------------------------------------
module pid_controller_clamped import pidc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   pidc_req_if.sink          req_if,
   pidc_rsp_if.source        rsp_if,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   pidc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pidc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pidc_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_measured    (req_if.measured),
      .rsp_drive       (rsp_if.drive),
      .rsp_was_clamped (rsp_if.was_clamped),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready)
   );

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_if.ready && !rsp_if.valid))
      else $error("not idle after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (!req_if.ready && !cmd.out_load))
      else $error("second sample taken while one in flight");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_if.valid)
      else $error("loaded result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> !cmd.out_load)
      else $error("pending result overwritten");

endmodule
